>>> src/tlv_stream_parser_macros.svh
// Assertion macros used by the checker of the parser.
`ifndef TLV_STREAM_PARSER_MACROS_SVH
`define TLV_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlv_stream_parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TLV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlv_stream_parser assertion failed");

`endif

>>> src/tlv_pkg.sv
package tlv_pkg;

  typedef enum logic [1:0] {
    ROLE_HEADER = 2'd0,
    ROLE_TYPE   = 2'd1,
    ROLE_LENGTH = 2'd2,
    ROLE_VALUE  = 2'd3
  } role_t;

  localparam int unsigned TailBytes = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tlv_in_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [7:0]  record_type;
    logic [31:0] record_length;
    logic [7:0]  value_byte;
    logic        record_done;
    logic        message_done;
    logic        end_tag_ok;
    logic        truncated;
  } tlv_out_t;

endpackage

>>> src/tlv_in_reg.sv
module tlv_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  tlv_pkg::tlv_in_t item,
  input  logic            advance,
  output logic            held_valid,
  output tlv_pkg::tlv_in_t held
);
  import tlv_pkg::*;

  logic take;

  assign item_stall = held_valid && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= take || (held_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= item;
    end
  end

endmodule

>>> src/tlv_core.sv
module tlv_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  logic             advance,
  input  tlv_pkg::tlv_in_t  held,
  output tlv_pkg::tlv_out_t res
);
  import tlv_pkg::*;

  role_t       phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [31:0] value_remaining, value_remaining_next;
  logic [7:0]  current_type, current_type_next;
  logic [31:0] current_length, current_length_next;
  logic [8*TailBytes-1:0] tail_bytes;
  logic [2:0]  bytes_seen;
  logic [7:0]  end_type_code;
  logic [31:0] rem_dec;
  logic        done;
  logic [7:0]  b;

  assign b       = held.data_byte;
  assign rem_dec = value_remaining - 32'd1;

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    value_remaining_next = value_remaining;
    current_type_next    = current_type;
    current_length_next  = current_length;
    done                 = 1'b0;
    case (phase)
      ROLE_HEADER: begin
        phase_next = ROLE_TYPE;
      end
      ROLE_TYPE: begin
        current_type_next   = b;
        current_length_next = '0;
        header_index_next   = '0;
        phase_next          = ROLE_LENGTH;
      end
      ROLE_LENGTH: begin
        current_length_next = {current_length[23:0], b};
        header_index_next   = header_index + 2'd1;
        if (header_index_next == 2'd0) begin
          value_remaining_next = current_length_next;
          if (current_length_next == 32'd0) begin
            done       = 1'b1;
            phase_next = ROLE_TYPE;
          end else begin
            phase_next = ROLE_VALUE;
          end
        end
      end
      default: begin
        value_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          done       = 1'b1;
          phase_next = ROLE_TYPE;
        end
      end
    endcase
  end

  always_comb begin
    res.byte_role     = phase;
    res.record_type   = current_type_next;
    res.record_length = current_length_next;
    res.value_byte    = (phase == ROLE_VALUE) ? b : 8'd0;
    res.record_done   = done;
    res.message_done  = held.last_byte;
    res.end_tag_ok    = held.last_byte && (bytes_seen >= 3'd4) && (b == 8'd0) &&
                        (tail_bytes[23:0] == 24'd0) && (tail_bytes[31:24] == end_type_code);
    res.truncated     = held.last_byte &&
                        ((phase_next == ROLE_LENGTH) || (phase_next == ROLE_VALUE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_type_code <= '0;
    end else if (cfg_we) begin
      end_type_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ROLE_HEADER;
      header_index    <= '0;
      value_remaining <= '0;
      current_type    <= '0;
      current_length  <= '0;
      tail_bytes      <= '0;
      bytes_seen      <= '0;
    end else if (advance) begin
      if (held.last_byte) begin
        phase           <= ROLE_HEADER;
        header_index    <= '0;
        value_remaining <= '0;
        current_type    <= '0;
        current_length  <= '0;
        tail_bytes      <= '0;
        bytes_seen      <= '0;
      end else begin
        phase           <= phase_next;
        header_index    <= header_index_next;
        value_remaining <= value_remaining_next;
        current_type    <= current_type_next;
        current_length  <= current_length_next;
        tail_bytes      <= {tail_bytes[8*TailBytes-9:0], b};
        if (bytes_seen < 3'd5) begin
          bytes_seen <= bytes_seen + 3'd1;
        end
      end
    end
  end

endmodule

>>> src/tlv_out_reg.sv
module tlv_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              held_valid,
  input  tlv_pkg::tlv_out_t  res,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output tlv_pkg::tlv_out_t  result
);
  import tlv_pkg::*;

  assign advance = held_valid && !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

>>> src/tlv_stream_parser.sv
// Type-length-value message parser. Each request carries one message byte and a
// last-byte flag; each result tags that byte with its role (header, type, length,
// value), the current record type and length, and record completion, and on the
// last byte reports the end-tag check and truncation. The block takes one byte
// per cycle while the result is not stalled: a byte is held in the input
// register, the parse state is updated from it in a single step, and its result
// is then held in the output register until taken. The end type code is written
// through the configuration channel, which is always ready.
module tlv_stream_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tlv_pkg::tlv_in_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tlv_pkg::tlv_out_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import tlv_pkg::*;

  logic     held_valid;
  logic     advance;
  tlv_in_t  held;
  tlv_out_t res;

  assign cfg_ready = 1'b1;

  tlv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  tlv_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .advance  (advance),
    .held     (held),
    .res      (res)
  );

  tlv_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> src/tlv_checker.sv
`include "tlv_stream_parser_macros.svh"

module tlv_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input tlv_pkg::tlv_out_t  result
);
  import tlv_pkg::*;

  `TLV_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))
  `TLV_ASSERT_NOW(a_header_clean, result_valid && (result.byte_role == ROLE_HEADER), (result.record_type == 8'd0) && (result.record_length == 32'd0))
  `TLV_ASSERT_NOW(a_value_only, result_valid && (result.byte_role != ROLE_VALUE), result.value_byte == 8'd0)
  `TLV_ASSERT_NOW(a_end_flags, result_valid && (result.end_tag_ok || result.truncated), result.message_done)

endmodule

bind tlv_stream_parser tlv_checker u_tlv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
